### design/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg: shared constants and types for the group reverse stream
// Sizes of the group store and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int MAX_GROUP = 16;
  localparam int IDX_W     = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int CFG_W     = 5;
  localparam int VAL_W     = 32;

  // controller -> datapath
  typedef struct packed {
    logic             store;       // write value at fill count, bump count
    logic             clear_fill;  // group closed, restart count
    logic             rd_en;       // issue a store read
    logic [IDX_W-1:0] rd_addr;
    logic             rd_last;     // last result of this group
    logic             rd_end;      // last result of the sequence
  } grs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             reach;       // fill count + 1 reaches group size
    logic [CNT_W-1:0] count_inc;   // fill count + 1
    logic             out_free;    // a read may be issued now
  } grs_stat_t;

endpackage

### design/grs_if.sv
// ----------------------------------------------------------------------------
// grs_if: stream channels of the group reverse stream
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface grs_in_if import grs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    seq_end;

  modport source (output valid, output value, output seq_end, input ready);
  modport sink   (input valid, input value, input seq_end, output ready);
endinterface

interface grs_out_if import grs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic                    run_last;
  logic                    out_seq_end;

  modport source (output valid, output out_value, output run_last, output out_seq_end,
                  input ready);
  modport sink   (input valid, input out_value, input run_last, input out_seq_end,
                  output ready);
endinterface

### design/grs_ram.sv
// ----------------------------------------------------------------------------
// grs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module grs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/grs_ctrl.sv
// ----------------------------------------------------------------------------
// grs_ctrl: group reverse stream controller
// Takes input beats while filling, then walks the closed group out.
// ----------------------------------------------------------------------------
module grs_ctrl import grs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_seq_end,
  output logic      in_ready,
  input  grs_stat_t st,
  output grs_cmd_t  cmd
);

  localparam logic S_FILL  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             rev_r, rev_nxt;
  logic             end_r, end_nxt;
  logic             fire;
  logic             at_last;
  logic [CNT_W-1:0] src;

  assign in_ready = (state_r == S_FILL);
  assign fire     = in_valid && in_ready;
  assign at_last  = (idx_r + CNT_W'(1)) == n_r;
  assign src      = rev_r ? (n_r - CNT_W'(1) - idx_r) : idx_r;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    rev_nxt   = rev_r;
    end_nxt   = end_r;
    cmd       = '0;
    cmd.rd_addr = src[IDX_W-1:0];
    unique case (state_r)
      S_FILL: begin
        if (fire) begin
          cmd.store = 1'b1;
          if (st.reach || in_seq_end) begin
            cmd.clear_fill = 1'b1;
            n_nxt     = st.count_inc;
            rev_nxt   = st.reach;
            end_nxt   = in_seq_end;
            idx_nxt   = '0;
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (st.out_free) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_last = at_last;
          cmd.rd_end  = at_last && end_r;
          idx_nxt     = idx_r + CNT_W'(1);
          if (at_last) begin
            state_nxt = S_FILL;
          end
        end
      end
      default: state_nxt = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
    end else begin
      state_r <= state_nxt;
    end
    n_r   <= n_nxt;
    idx_r <= idx_nxt;
    rev_r <= rev_nxt;
    end_r <= end_nxt;
  end

endmodule

### design/grs_dp.sv
// ----------------------------------------------------------------------------
// grs_dp: group reverse stream datapath
// Group size register, fill count, group store and the result register.
// ----------------------------------------------------------------------------
module grs_dp import grs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic signed [VAL_W-1:0] in_value,
  input  grs_cmd_t                cmd,
  output grs_stat_t               st,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_run_last,
  output logic                    out_seq_end
);

  logic [CFG_W-1:0] gsize_r;
  logic [CNT_W-1:0] k_eff;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             rd_pend_r, rd_last_r, rd_end_r;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r;
  logic             out_last_r, out_end_r;
  logic [VAL_W-1:0] rd_data;

  // zero acts as one, oversize clamps to the store depth
  always_comb begin
    if (gsize_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (gsize_r > CFG_W'(MAX_GROUP)) begin
      k_eff = CNT_W'(MAX_GROUP);
    end else begin
      k_eff = CNT_W'(gsize_r);
    end
  end

  assign st.count_inc = fill_r + CNT_W'(1);
  assign st.reach     = st.count_inc >= k_eff;
  assign st.out_free  = !rd_pend_r && (!out_valid_r || out_ready);

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.clear_fill) begin
      fill_nxt = '0;
    end else if (cmd.store) begin
      fill_nxt = st.count_inc;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  grs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_GROUP)) u_store (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (fill_r[IDX_W-1:0]),
    .wr_data (in_value),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsize_r     <= CFG_W'(1);
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        gsize_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      rd_pend_r   <= cmd.rd_en;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.rd_en) begin
      rd_last_r <= cmd.rd_last;
      rd_end_r  <= cmd.rd_end;
    end
    if (rd_pend_r) begin
      out_value_r <= rd_data;
      out_last_r  <= rd_last_r;
      out_end_r   <= rd_end_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_run_last = out_last_r;
  assign out_seq_end  = out_end_r;

`ifndef SYNTHESIS
  a_rd_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !rd_pend_r)
    else $error("read issued while previous read pending");

  a_rd_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_valid_r)
    else $error("read data did not reach result register");

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (fill_r < CNT_W'(MAX_GROUP)))
    else $error("store write beyond group depth");

  a_no_store_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> !cmd.rd_en)
    else $error("store write during group drain");
`endif

endmodule

### design/group_reverse_stream.sv
// ----------------------------------------------------------------------------
// group_reverse_stream: reverse a value stream in groups of k
// Top level: controller plus datapath, valid/ready channels, one config reg.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  carries value and seq_end beats; out_bus carries out_value,
//   run_last and out_seq_end beats. A beat moves when valid and ready are high.
//   cfg_we/cfg_wdata write the group size (0 acts as 1, above 16 acts as 16);
//   write it only while the block is idle.
// Timing:
//   A beat that neither fills the group nor ends the sequence is only stored,
//   so a group streams in at one beat per cycle while the block is filling.
//   The beat that closes a group of n values starts a drain: each result is a
//   store read then a result register load, and the next read waits until
//   that load is done. The first result passes through the drain state, the
//   store read register and the result register. in_bus.ready is low during the
//   drain and high again as soon as the last read is issued, while the last
//   result may still sit in the output register.
// Reset: rst_n (synchronous, active low) empties the group, drops out valid
//   and sets the group size to 1. Store contents are not cleared.
// Stall: when out_bus.ready is low the result register holds its beat and the
//   drain pauses; nothing is dropped.
// ----------------------------------------------------------------------------
module group_reverse_stream import grs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  grs_in_if.sink           in_bus,
  grs_out_if.source        out_bus,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  grs_cmd_t  cmd;   // controller commands to datapath
  grs_stat_t st;    // datapath status back

  // controller: fill / drain sequencing and read addressing
  grs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_seq_end (in_bus.seq_end),
    .in_ready   (in_bus.ready),
    .st         (st),
    .cmd        (cmd)
  );

  // datapath: group store, fill count, result register
  grs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_value     (in_bus.value),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .out_value    (out_bus.out_value),
    .out_run_last (out_bus.run_last),
    .out_seq_end  (out_bus.out_seq_end)
  );

endmodule

### sim/group_reverse_stream_tb.sv
// ----------------------------------------------------------------------------
// group_reverse_stream_tb: self-checking bench for the group reverse stream
// Drives value beats through the input channel, mirrors the grouping and
// reversal in a local model, and checks every result beat in order. Runs
// directed cases for the size corners, then long randomized sequences over
// several group sizes, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module group_reverse_stream_tb;
  import grs_pkg::*;

  // Wait that covers the drain of a full group, with slack.
  localparam int DRAIN_CYC   = 2 * MAX_GROUP + 8;
  // Worst case is far below this: at most about 840 beats, one result each, every
  // result waiting out the longest random stall, plus sender gaps and the long hold.
  localparam int CYCLE_LIMIT = 900_000;
  localparam int HOLD_CYC    = 80;
  localparam int MAX_PRINTS  = 40;
  localparam int PHASE_BEATS = 32;
  localparam int NUM_PHASES  = 10;

  // One result beat as the block should present it.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    run_last;
    logic                    seq_end;
  } res_beat_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  grs_in_if  in_bus ();
  grs_out_if out_bus ();

  group_reverse_stream u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Local model of the reorder: held values, fill count, group size register.
  // --------------------------------------------------------------------------
  logic [VAL_W-1:0] held_vals [MAX_GROUP];
  int unsigned      held_cnt;
  logic [CFG_W-1:0] grp_size;
  res_beat_t        pending_results[$];

  // Bookkeeping
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned beats_in;
  int unsigned results_ok;
  int unsigned size_writes;

  // Idle controls, flipped by the test tasks
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;

  res_beat_t want;

  // Accept one value into the group; queue whatever the block should emit.
  function automatic void reorder_group(logic [VAL_W-1:0] v, logic last);
    int unsigned k;
    int unsigned n;
    int unsigned src;
    bit          rev;
    res_beat_t   r;
    // 0 acts as 1, anything over the store depth acts as the full depth
    k = (grp_size == 0) ? 1 : ((grp_size > MAX_GROUP) ? MAX_GROUP : grp_size);
    if (held_cnt < MAX_GROUP) begin
      held_vals[held_cnt] = v;
      held_cnt++;
    end
    n = held_cnt;
    if (n >= k) begin
      rev = 1'b1;
    end else if (last) begin
      rev = 1'b0;           // short tail at sequence end: arrival order
    end else begin
      return;               // still collecting, nothing comes out
    end
    for (int unsigned i = 0; i < n; i++) begin
      src        = rev ? (n - 1 - i) : i;
      r.value    = held_vals[src];
      r.run_last = (i + 1 == n);
      r.seq_end  = last && (i + 1 == n);
      pending_results.push_back(r);
    end
    held_cnt = 0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS)
      $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: ready generator. Random stall bursts when enabled; a long
  // hold when a test raises hold_req, counted here so the sender keeps going.
  // --------------------------------------------------------------------------
  initial begin : rx_ready_gen
    int unsigned burst;
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        for (int unsigned c = 1; c < HOLD_CYC; c++) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_bus.ready <= 1'b0;
        burst = $urandom_range(1, 17);
        repeat (burst - 1) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Result checker: compares each accepted result beat with the oldest
  // queued one. Pre-edge values are seen since all drives are nonblocking.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing queued",
                                  out_bus.out_value));
      end else begin
        want = pending_results.pop_front();
        if (out_bus.out_value !== want.value)
          report_mismatch($sformatf("out_value %0d, model %0d",
                                    out_bus.out_value, want.value));
        if (out_bus.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, model %b (value %0d)",
                                    out_bus.run_last, want.run_last, want.value));
        if (out_bus.out_seq_end !== want.seq_end)
          report_mismatch($sformatf("out_seq_end %b, model %b (value %0d)",
                                    out_bus.out_seq_end, want.seq_end, want.value));
        results_ok++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one beat and hold it until taken. Called at a rising edge; valid
  // stays high across back-to-back calls, so only one drive per step.
  task automatic send_beat(input logic signed [VAL_W-1:0] v, input logic last);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.value   <= v;
    in_bus.seq_end <= last;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    // taken at this edge
    reorder_group(v, last);
    beats_in++;
  endtask

  task automatic stop_sending();
    in_bus.valid <= 1'b0;
  endtask

  // Wait for every queued result, then let the block settle. A partial group
  // produces nothing, so the quiet period covers any drain still in flight.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_group_size(input logic [CFG_W-1:0] k);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grp_size  = k;
    size_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset size is 1: each beat comes straight back.
  task automatic test_pass_through();
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh8000_0000, 1'b1);
    stop_sending();
  endtask

  // Size 3: full group closed by the sequence end comes out reversed with the
  // end flag; then a short tail of two comes out in arrival order.
  task automatic test_group_reverse();
    set_group_size(5'd3);
    send_beat(32'sh0000_0000, 1'b0);
    send_beat(-32'sd1,        1'b0);
    send_beat(32'sh8000_0000, 1'b1);
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh1234_5678, 1'b1);
    stop_sending();
  endtask

  // Size 0 behaves as 1.
  task automatic test_size_zero();
    set_group_size(5'd0);
    send_beat(32'sh5a5a_a5a5, 1'b0);
    stop_sending();
  endtask

  // Group of 5 half filled, size dropped to 2: next beat flushes all 4.
  task automatic test_mid_group_resize();
    set_group_size(5'd5);
    send_beat(32'sd11, 1'b0);
    send_beat(32'sd22, 1'b0);
    send_beat(32'sd33, 1'b0);
    stop_sending();
    set_group_size(5'd2);
    send_beat(32'sd44, 1'b0);
    stop_sending();
  endtask

  // Size above the store depth clamps to 16: the 16th beat closes the group.
  task automatic test_size_too_large();
    set_group_size(5'd20);
    for (int i = 0; i < MAX_GROUP; i++)
      send_beat($signed($urandom()), 1'b0);
    stop_sending();
  endtask

  // Output held off long while the sender keeps offering back to back; the
  // block must fill, stall its input and lose nothing.
  task automatic test_backpressure();
    bit tx_save;
    bit rx_save;
    tx_save    = tx_idle_en;
    rx_save    = rx_idle_en;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_group_size(5'd4);
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_beat($signed($urandom()), (i == 11));
    stop_sending();
    wait_drained();
    tx_idle_en = tx_save;
    rx_idle_en = rx_save;
  endtask

  // Random sequences over a list of group sizes. Most are well formed (end
  // flag only on the last beat); some carry random end flags. A phase may end
  // mid-group, so the next size write lands on a partly filled group.
  task automatic test_random();
    logic [CFG_W-1:0]        sizes [NUM_PHASES];
    int unsigned             eff;
    int unsigned             sent;
    int unsigned             len;
    bit                      noise;
    logic signed [VAL_W-1:0] v;
    logic                    last;
    sizes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd7, 5'd17, 5'd3, 5'd0, 5'd0};
    sizes[8] = CFG_W'($urandom_range(1, 16));
    sizes[9] = CFG_W'($urandom_range(0, 31));
    for (int p = 0; p < NUM_PHASES; p++) begin
      // last two phases run with no idling at all
      tx_idle_en = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      set_group_size(sizes[p]);
      eff  = (sizes[p] == 0) ? 1 : ((sizes[p] > MAX_GROUP) ? MAX_GROUP : sizes[p]);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, eff)
                                            : $urandom_range(1, 3 * eff + 1);
        noise = ($urandom_range(0, 7) == 0);
        for (int unsigned j = 0; j < len; j++) begin
          case ($urandom_range(0, 9))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2:       v = -32'sd1;
            3:       v = 32'sd0;
            default: v = $signed($urandom());
          endcase
          last = noise ? 1'($urandom_range(0, 1)) : (j + 1 == len);
          send_beat(v, last);
          sent++;
        end
      end
      stop_sending();
    end
    // close out any partial group so every beat is checked
    send_beat($signed($urandom()), 1'b1);
    stop_sending();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_bus.valid   <= 1'b0;
    in_bus.value   <= '0;
    in_bus.seq_end <= 1'b0;
    cycle_cnt   = 0;
    err_cnt     = 0;
    beats_in    = 0;
    results_ok  = 0;
    size_writes = 0;
    held_cnt    = 0;
    grp_size    = 5'd1;
    hold_req    = 1'b0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_pass_through();
    test_group_reverse();
    test_size_zero();
    test_mid_group_resize();
    test_size_too_large();
    test_backpressure();
    test_random();

    wait_drained();

    $display("Ran %0d value beats, checked %0d result beats, %0d group size writes",
             beats_in, results_ok, size_writes);
    $display("Sizes covered 0, 1, 16 and clamped values, mid-group resize, long output hold");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
